>>> sv/vcxb_pkg.sv
// Shared types, sizes and register codes of the virtual channel crossbar.
`timescale 1ns / 1ps
package vcxb_pkg;

	localparam int NODES        = 8;
	localparam int VCS          = 2;
	localparam int QDEPTH       = 8;
	localparam int PAYLOAD_BITS = 32;

	localparam int NODE_W = 3;
	localparam int Q_W    = 4;
	localparam int SLOT_W = 3;
	localparam int CNT_W  = 4;
	localparam int NQ     = NODES * VCS;
	localparam int ADDR_W = Q_W + SLOT_W;
	localparam int IN_W   = NODE_W + PAYLOAD_BITS;

	typedef enum logic [2:0] {
		REG_ARBITER_MODE = 3'd0,
		REG_GRANT_PERIOD = 3'd1,
		REG_IN_LIMIT     = 3'd2,
		REG_OUT_LIMIT    = 3'd3,
		REG_NODES        = 3'd4,
		REG_VCS          = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		REQ_PUSH    = 2'd0,
		REQ_POP     = 2'd1,
		REQ_ADVANCE = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	localparam logic       RST_MODE     = 1'b0;
	localparam logic [7:0] RST_PERIOD   = 8'd1;
	localparam logic [3:0] RST_IN_LIM   = 4'd8;
	localparam logic [3:0] RST_OUT_LIM  = 4'd8;
	localparam logic [3:0] RST_NODES    = 4'd8;
	localparam logic [1:0] RST_VCS      = 2'd1;

	// Reduces a small value modulo the active node count (2..8).
	function automatic logic [NODE_W-1:0] wrap_node(input logic [3:0] x, input logic [3:0] n);
		logic [3:0] r;
		r = x;
		for (int k = 0; k < 4; k++) begin
			if (r >= n) r = r - n;
		end
		return r[NODE_W-1:0];
	endfunction

endpackage

>>> sv/vcxb_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
module vcxb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

>>> sv/vc_crossbar_switch_arbiter_top.sv
// Top level of the virtual channel crossbar switch with round robin and iSLIP arbitration.
//
// Channel   Handshake          Payload
// request   req_valid/ready    req_type, src_node, dst_node, channel, payload
// result    res_valid/ready    accepted, out_valid, out_payload, moved_count, busy_res
// config    APB write/read     paddr, pwdata, prdata (six registers at 4*i)
//
// Push and pop pass through their own state and the finish state before the result
// is raised. An advance tick is run by one sequencer that visits node and channel
// pairs, each visit a packet store read, then one compare and move step. The visits
// share the input packet store read port. Reset clears all queue heads, counts and
// arbiter pointers at once; the packet stores need no clearing. A new request is
// taken only once the previous result has been transferred out.
`timescale 1ns / 1ps
module vc_crossbar_switch_arbiter_top
	import vcxb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  logic [1:0]              req_type,
	input  logic [2:0]              src_node,
	input  logic [2:0]              dst_node,
	input  logic                    channel,
	input  logic [31:0]             payload,
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic                    accepted,
	output logic                    out_valid,
	output logic [31:0]             out_payload,
	output logic [3:0]              moved_count,
	output logic                    busy_res,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [4:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PUSH = 6'b000010,
		ST_POP  = 6'b000100,
		ST_TRD  = 6'b001000,
		ST_TCHK = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic       mode_q;
	logic [7:0] period_q;
	logic [3:0] in_lim_q, out_lim_q, nodes_q;
	logic [1:0] vcs_q;

	// Queue bookkeeping and arbiter state.
	logic [SLOT_W-1:0] in_head_q  [NQ];
	logic [CNT_W-1:0]  in_cnt_q   [NQ];
	logic [SLOT_W-1:0] out_head_q [NQ];
	logic [CNT_W-1:0]  out_cnt_q  [NQ];
	logic              last_q     [NODES];
	logic [NODE_W-1:0] gp_q       [NODES];
	logic [NODE_W-1:0] rr_start_q;
	logic [7:0]        cd_q;

	// Sequencer counters.
	logic [NODE_W-1:0] node_q, j_q, o_q;
	logic              it_q;
	logic [NODES-1:0]  granted_q;
	logic              active_q;
	logic              res_valid_q;

	// Latched request and result registers.
	logic [1:0]  rtype_q;
	logic [2:0]  rsrc_q, rdst_q;
	logic        rch_q;
	logic [31:0] rpay_q;
	logic        acc_q, oval_q, busy_q;
	logic [31:0] opay_q;
	logic [3:0]  moved_q;

	// Effective counts and limits after saturation.
	logic [3:0] eff_n, ilim, olim;
	logic [1:0] eff_v;

	assign eff_n = (nodes_q < 4'd2) ? 4'd2 : ((nodes_q > 4'd8) ? 4'd8 : nodes_q);
	assign eff_v = (vcs_q == 2'd0) ? 2'd1 : ((vcs_q > 2'd2) ? 2'd2 : vcs_q);
	assign ilim  = (in_lim_q > 4'd8) ? 4'd8 : in_lim_q;
	assign olim  = (out_lim_q > 4'd8) ? 4'd8 : out_lim_q;

	// Push checks against the latched request.
	logic [Q_W-1:0] push_qi;
	logic           push_ok;
	assign push_qi = {rsrc_q, rch_q};
	assign push_ok = ({1'b0, rsrc_q} < eff_n) && ({1'b0, rdst_q} < eff_n) &&
		({1'b0, rch_q} < eff_v) && (in_cnt_q[push_qi] < ilim);

	// Pop checks.
	logic [Q_W-1:0] pop_qi;
	logic           pop_ok;
	assign pop_qi = {rdst_q, rch_q};
	assign pop_ok = ({1'b0, rdst_q} < eff_n) && ({1'b0, rch_q} < eff_v) &&
		(out_cnt_q[pop_qi] != 4'd0);

	// Visit under way: node, channel and the head packet read from the store.
	logic              cur_ch;
	logic [Q_W-1:0]    cur_q, tgt_q;
	logic [IN_W-1:0]   in_rdata;
	logic [NODE_W-1:0] rd_dst, tgt;
	logic [31:0]       rd_tag;
	logic              move;

	assign cur_ch = (eff_v == 2'd1) ? 1'b0 : ~(last_q[node_q] ^ it_q);
	assign cur_q  = {node_q, cur_ch};
	assign rd_dst = in_rdata[IN_W-1:PAYLOAD_BITS];
	assign rd_tag = in_rdata[PAYLOAD_BITS-1:0];
	assign tgt    = mode_q ? o_q : rd_dst;
	assign tgt_q  = {tgt, cur_ch};
	assign move   = (in_cnt_q[cur_q] != 4'd0) && (out_cnt_q[tgt_q] < olim) &&
		(mode_q ? (rd_dst == o_q)
		        : (({1'b0, rd_dst} < eff_n) && !granted_q[rd_dst]));

	// Position of the visit within the scan.
	logic last_it, last_j, last_o;
	logic [NODE_W-1:0] node_nx, o_nx;
	assign last_it = ({1'b0, it_q} == (eff_v - 2'd1));
	assign last_j  = ({1'b0, j_q} == (eff_n - 4'd1));
	assign last_o  = ({1'b0, o_q} == (eff_n - 4'd1));
	assign node_nx = ({1'b0, node_q} + 4'd1 == eff_n) ? '0 : node_q + 3'd1;
	assign o_nx    = o_q + 3'd1;

	// Packet stores.
	logic              in_we, out_we;
	logic [ADDR_W-1:0] in_waddr, in_raddr, out_waddr, out_raddr;
	logic [31:0]       out_rdata;
	logic [SLOT_W-1:0] in_tail, out_tail;

	assign in_tail   = in_head_q[push_qi] + in_cnt_q[push_qi][SLOT_W-1:0];
	assign in_we     = (state_q == ST_PUSH) && push_ok;
	assign in_waddr  = {push_qi, in_tail};
	assign in_raddr  = {cur_q, in_head_q[cur_q]};
	assign out_tail  = out_head_q[tgt_q] + out_cnt_q[tgt_q][SLOT_W-1:0];
	assign out_we    = (state_q == ST_TCHK) && move;
	assign out_waddr = {tgt_q, out_tail};
	assign out_raddr = {pop_qi, out_head_q[pop_qi]};

	vcxb_ram #(.WIDTH(IN_W), .DEPTH(NQ * QDEPTH)) u_in_store (
		.clk   (clk),
		.we    (in_we),
		.waddr (in_waddr),
		.wdata ({rdst_q, rpay_q}),
		.raddr (in_raddr),
		.rdata (in_rdata)
	);

	vcxb_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(NQ * QDEPTH)) u_out_store (
		.clk   (clk),
		.we    (out_we),
		.waddr (out_waddr),
		.wdata (rd_tag),
		.raddr (out_raddr),
		.rdata (out_rdata)
	);

	// Activity before an iSLIP tick and occupancy after each step.
	logic active_now, busy_now;
	always_comb begin
		active_now = 1'b0;
		busy_now   = 1'b0;
		for (int k = 0; k < NQ; k++) begin
			if ((k / VCS) < int'(eff_n) && (k % VCS) < int'(eff_v) && in_cnt_q[k] != 4'd0)
				active_now = 1'b1;
			if (in_cnt_q[k] != 4'd0 || out_cnt_q[k] != 4'd0) busy_now = 1'b1;
		end
	end

	// APB port: writes complete in the access phase, reads return the register.
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		unique case (paddr[4:2])
			REG_ARBITER_MODE: prdata = {31'd0, mode_q};
			REG_GRANT_PERIOD: prdata = {24'd0, period_q};
			REG_IN_LIMIT:     prdata = {28'd0, in_lim_q};
			REG_OUT_LIMIT:    prdata = {28'd0, out_lim_q};
			REG_NODES:        prdata = {28'd0, nodes_q};
			REG_VCS:          prdata = {30'd0, vcs_q};
			default:          prdata = '0;
		endcase
	end

	assign req_ready = (state_q == ST_IDLE) && !res_valid_q;
	assign res_valid = res_valid_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= RST_MODE;
			period_q    <= RST_PERIOD;
			in_lim_q    <= RST_IN_LIM;
			out_lim_q   <= RST_OUT_LIM;
			nodes_q     <= RST_NODES;
			vcs_q       <= RST_VCS;
			rr_start_q  <= '0;
			cd_q        <= 8'd1;
			res_valid_q <= 1'b0;
			node_q      <= '0;
			j_q         <= '0;
			o_q         <= '0;
			it_q        <= 1'b0;
			granted_q   <= '0;
			active_q    <= 1'b0;
			for (int k = 0; k < NQ; k++) begin
				in_head_q[k]  <= '0;
				in_cnt_q[k]   <= '0;
				out_head_q[k] <= '0;
				out_cnt_q[k]  <= '0;
			end
			for (int k = 0; k < NODES; k++) begin
				last_q[k] <= 1'b0;
				gp_q[k]   <= '0;
			end
		end else begin
			if (cfg_wr) begin
				unique case (paddr[4:2])
					REG_ARBITER_MODE: mode_q    <= pwdata[0];
					REG_GRANT_PERIOD: period_q  <= pwdata[7:0];
					REG_IN_LIMIT:     in_lim_q  <= pwdata[3:0];
					REG_OUT_LIMIT:    out_lim_q <= pwdata[3:0];
					REG_NODES:        nodes_q   <= pwdata[3:0];
					REG_VCS:          vcs_q     <= pwdata[1:0];
					default: ;
				endcase
			end
			if (res_valid_q && res_ready) res_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid && req_ready) begin
						active_q  <= active_now;
						granted_q <= '0;
						j_q       <= '0;
						it_q      <= 1'b0;
						o_q       <= '0;
						node_q    <= (req_type[1] == 1'b0) ? '0 :
							(mode_q ? wrap_node({1'b0, gp_q[0]}, eff_n)
							        : wrap_node({1'b0, rr_start_q}, eff_n));
						unique case (req_type)
							REQ_PUSH:    state_q <= ST_PUSH;
							REQ_POP:     state_q <= ST_POP;
							REQ_ADVANCE: state_q <= ST_TRD;
							default:     state_q <= ST_FIN;
						endcase
					end
				end
				ST_PUSH: begin
					if (push_ok) in_cnt_q[push_qi] <= in_cnt_q[push_qi] + 4'd1;
					state_q <= ST_FIN;
				end
				ST_POP: begin
					if (pop_ok) begin
						out_head_q[pop_qi] <= out_head_q[pop_qi] + 3'd1;
						out_cnt_q[pop_qi]  <= out_cnt_q[pop_qi] - 4'd1;
					end
					state_q <= ST_FIN;
				end
				ST_TRD: state_q <= ST_TCHK;
				ST_TCHK: begin
					state_q <= ST_TRD;
					if (move) begin
						out_cnt_q[tgt_q]  <= out_cnt_q[tgt_q] + 4'd1;
						in_head_q[cur_q]  <= in_head_q[cur_q] + 3'd1;
						in_cnt_q[cur_q]   <= in_cnt_q[cur_q] - 4'd1;
						last_q[node_q]    <= cur_ch;
						granted_q[rd_dst] <= 1'b1;
						if (mode_q && cd_q == 8'd1) gp_q[o_q] <= node_nx;
					end
					if (!mode_q) begin
						if (move || last_it) begin
							if (last_j) begin
								rr_start_q <= wrap_node({1'b0, rr_start_q} + 4'd1, eff_n);
								state_q    <= ST_FIN;
							end else begin
								j_q    <= j_q + 3'd1;
								node_q <= node_nx;
								it_q   <= 1'b0;
							end
						end else begin
							it_q <= 1'b1;
						end
					end else begin
						if (move || (last_it && last_j)) begin
							if (last_o) begin
								if (active_q) cd_q <= (cd_q == 8'd1) ? period_q : cd_q - 8'd1;
								state_q <= ST_FIN;
							end else begin
								o_q    <= o_nx;
								node_q <= wrap_node({1'b0, gp_q[o_nx]}, eff_n);
								j_q    <= '0;
								it_q   <= 1'b0;
							end
						end else if (!last_it) begin
							it_q <= 1'b1;
						end else begin
							j_q    <= j_q + 3'd1;
							node_q <= node_nx;
							it_q   <= 1'b0;
						end
					end
				end
				ST_FIN: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid && req_ready) begin
			rtype_q <= req_type;
			rsrc_q  <= src_node;
			rdst_q  <= dst_node;
			rch_q   <= channel;
			rpay_q  <= payload;
			acc_q   <= (req_type == REQ_ADVANCE);
			oval_q  <= 1'b0;
			moved_q <= '0;
		end
		if (state_q == ST_PUSH) acc_q <= push_ok;
		if (state_q == ST_POP)  oval_q <= pop_ok;
		if (state_q == ST_TCHK && move) moved_q <= moved_q + 4'd1;
		if (state_q == ST_FIN) begin
			opay_q <= (oval_q && rtype_q == REQ_POP) ? out_rdata : 32'd0;
			busy_q <= busy_now;
		end
	end

	assign accepted    = acc_q;
	assign out_valid   = oval_q;
	assign out_payload = opay_q;
	assign moved_count = moved_q;
	assign busy_res    = busy_q;

endmodule

>>> bench/vc_crossbar_switch_arbiter_top_tb.sv
// Self-checking testbench for the virtual channel crossbar switch and its two arbiters.
`timescale 1ns / 1ps
module vc_crossbar_switch_arbiter_top_tb;
	import vcxb_pkg::*;

	// One expected or observed result of a request.
	typedef struct packed {
		logic        accepted;
		logic        out_valid;
		logic [31:0] out_payload;
		logic [3:0]  moved_count;
		logic        busy_res;
	} xb_result_t;

	// Switch predictor: its own copy of the queues, pointers and registers.
	class xbar_scoreboard;
		logic [31:0] in_tag [NQ][QDEPTH];
		logic [2:0]  in_dst [NQ][QDEPTH];
		int          in_head [NQ];
		int          in_cnt [NQ];
		logic [31:0] out_tag [NQ][QDEPTH];
		int          out_head [NQ];
		int          out_cnt [NQ];
		int          last_ch [NODES];
		int          rr_start;
		int          gptr [NODES];
		logic [7:0]  countdown;
		logic        mode;
		logic [7:0]  period;
		logic [3:0]  in_lim, out_lim, nodes_reg;
		logic [1:0]  vcs_reg;
		xb_result_t  pending[$];
		int          errors;

		function new();
			errors = 0;
			mode = RST_MODE; period = RST_PERIOD; in_lim = RST_IN_LIM;
			out_lim = RST_OUT_LIM; nodes_reg = RST_NODES; vcs_reg = RST_VCS;
			rr_start = 0; countdown = 8'd1;
			for (int q = 0; q < NQ; q++) begin
				in_head[q] = 0; in_cnt[q] = 0; out_head[q] = 0; out_cnt[q] = 0;
			end
			for (int k = 0; k < NODES; k++) begin
				last_ch[k] = 0; gptr[k] = 0;
			end
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] val);
			case (idx)
				REG_ARBITER_MODE: mode = val[0];
				REG_GRANT_PERIOD: period = val[7:0];
				REG_IN_LIMIT:     in_lim = val[3:0];
				REG_OUT_LIMIT:    out_lim = val[3:0];
				REG_NODES:        nodes_reg = val[3:0];
				REG_VCS:          vcs_reg = val[1:0];
				default: ;
			endcase
		endfunction

		function int n_eff();
			return nodes_reg < 2 ? 2 : (nodes_reg > NODES ? NODES : nodes_reg);
		endfunction
		function int v_eff();
			return vcs_reg < 1 ? 1 : (vcs_reg > VCS ? VCS : vcs_reg);
		endfunction
		function int clip(logic [3:0] x);
			return x > QDEPTH ? QDEPTH : x;
		endfunction
		function bit has_room(int q);
			return out_cnt[q] + 1 <= clip(out_lim);
		endfunction

		function void move_packet(int qi, int qo);
			out_tag[qo][(out_head[qo] + out_cnt[qo]) % QDEPTH] = in_tag[qi][in_head[qi]];
			out_cnt[qo]++;
			in_head[qi] = (in_head[qi] + 1) % QDEPTH;
			in_cnt[qi]--;
		endfunction

		function int tick_round_robin();
			int n, v, moved, nd, ch, q, d;
			bit granted [NODES];
			n = n_eff(); v = v_eff(); moved = 0;
			foreach (granted[k]) granted[k] = 0;
			for (int i = 0; i < n; i++) begin
				nd = (i + rr_start) % n;
				for (int it = 0; it < v; it++) begin
					ch = (last_ch[nd] + it + 1) % v;
					q = nd * VCS + ch;
					if (in_cnt[q] == 0) continue;
					d = in_dst[q][in_head[q]];
					if (d >= n || granted[d] || !has_room(d * VCS + ch)) continue;
					move_packet(q, d * VCS + ch);
					last_ch[nd] = ch; granted[d] = 1; moved++;
					break;
				end
			end
			rr_start = (rr_start + 1) % n;
			return moved;
		endfunction

		function int tick_islip();
			int n, v, moved, nd, c, q;
			bit active, any, done;
			bit room [VCS];
			n = n_eff(); v = v_eff(); moved = 0; active = 0;
			for (int o = 0; o < n; o++)
				for (int ch = 0; ch < v; ch++)
					if (in_cnt[o * VCS + ch] != 0) active = 1;
			for (int o = 0; o < n; o++) begin
				any = 0; done = 0;
				for (int ch = 0; ch < v; ch++) begin
					room[ch] = has_room(o * VCS + ch);
					if (room[ch]) any = 1;
				end
				if (!any) continue;
				for (int j = 0; j < n && !done; j++) begin
					nd = (j + gptr[o]) % n;
					for (int it = 0; it < v; it++) begin
						c = (last_ch[nd] + it + 1) % v;
						q = nd * VCS + c;
						if (in_cnt[q] == 0 || in_dst[q][in_head[q]] != o || !room[c])
							continue;
						move_packet(q, o * VCS + c);
						last_ch[nd] = c;
						if (countdown == 8'd1) gptr[o] = (nd + 1) % n;
						moved++; done = 1;
						break;
					end
				end
			end
			if (active) countdown = (countdown == 8'd1) ? period : countdown - 8'd1;
			return moved;
		endfunction

		// Notes an accepted request and queues the result it must produce.
		function void note_request(req_t rt, logic [2:0] s, logic [2:0] d, logic ch,
				logic [31:0] pl);
			xb_result_t r;
			int n, v, q;
			n = n_eff(); v = v_eff();
			r = '0;
			if (rt == REQ_PUSH) begin
				if (s < n && d < n && ch < v) begin
					q = s * VCS + ch;
					if (in_cnt[q] + 1 <= clip(in_lim)) begin
						in_tag[q][(in_head[q] + in_cnt[q]) % QDEPTH] = pl;
						in_dst[q][(in_head[q] + in_cnt[q]) % QDEPTH] = d;
						in_cnt[q]++;
						r.accepted = 1;
					end
				end
			end else if (rt == REQ_POP) begin
				if (d < n && ch < v) begin
					q = d * VCS + ch;
					if (out_cnt[q] != 0) begin
						r.out_payload = out_tag[q][out_head[q]];
						out_head[q] = (out_head[q] + 1) % QDEPTH;
						out_cnt[q]--;
						r.out_valid = 1;
					end
				end
			end else if (rt == REQ_ADVANCE) begin
				r.accepted = 1;
				r.moved_count = mode ? tick_islip() : tick_round_robin();
			end
			for (int k = 0; k < NQ; k++)
				if (in_cnt[k] != 0 || out_cnt[k] != 0) r.busy_res = 1;
			pending = {pending, r};
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			errors++;
		endtask

		// Compares one transferred result with the oldest expectation.
		task check_result(xb_result_t got);
			xb_result_t w;
			if (pending.size() == 0) begin
				report("unexpected result", 0, 0);
				return;
			end
			w = pending.pop_front();
			if (got.accepted !== w.accepted)
				report("accepted", 32'(got.accepted), 32'(w.accepted));
			if (got.out_valid !== w.out_valid)
				report("out_valid", 32'(got.out_valid), 32'(w.out_valid));
			if (got.out_payload !== w.out_payload)
				report("out_payload", got.out_payload, w.out_payload);
			if (got.moved_count !== w.moved_count)
				report("moved_count", 32'(got.moved_count), 32'(w.moved_count));
			if (got.busy_res !== w.busy_res)
				report("busy_res", 32'(got.busy_res), 32'(w.busy_res));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        req_valid = 0, res_ready = 0;
	logic        req_ready, res_valid;
	logic [1:0]  req_type = REQ_NONE;
	logic [2:0]  src_node = 0, dst_node = 0;
	logic        channel = 0;
	logic [31:0] payload = 0;
	logic        accepted, out_valid, busy_res;
	logic [31:0] out_payload, prdata;
	logic [3:0]  moved_count;
	logic        psel = 0, penable = 0, pwrite = 0, pready;
	logic [4:0]  paddr = 0;
	logic [31:0] pwdata = 0;

	xbar_scoreboard sb;
	int send_idle_pct, recv_stall_pct;
	longint cycle_count;
	localparam longint CYCLE_LIMIT = 2000000;

	vc_crossbar_switch_arbiter_top dut (.*);

	always #6 clk = ~clk;

	// The cycle counter guards against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// The receiver stalls at random and checks every transferred result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready)
				sb.check_result({accepted, out_valid, out_payload, moved_count, busy_res});
			res_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// An APB write: setup cycle, then access cycle; the model follows the register.
	// The bus is released by configure once the last write is done.
	task automatic write_register(reg_idx_t idx, logic [31:0] val);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= 5'(4 * idx); pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	// Drives one request, idling first as the current phase asks. Valid stays high
	// after the transfer; an idle cycle, a drain or a hold of the sender takes it down.
	task automatic send_request(req_t rt, logic [2:0] s, logic [2:0] d, logic ch,
			logic [31:0] pl);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1; req_type <= rt; src_node <= s; dst_node <= d;
		channel <= ch; payload <= pl;
		do @(posedge clk); while (!req_ready);
		sb.note_request(rt, s, d, ch, pl);
	endtask

	// Waits until every expected result has been transferred, then idles a
	// while before registers may change.
	task automatic drain();
		req_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	// A random item; pushes go mostly to valid nodes so queues fill and move.
	task automatic random_item(int n, int v);
		int sel;
		logic [2:0] s, d;
		sel = $urandom_range(99);
		s = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(n - 1));
		d = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(n - 1));
		if (sel < 40)
			send_request(REQ_PUSH, s, d, ($urandom_range(9) == 0) ? 1'($urandom)
				: 1'($urandom_range(v - 1)), $urandom);
		else if (sel < 70)
			send_request(REQ_POP, s, d, 1'($urandom_range(v - 1)), $urandom);
		else if (sel < 97)
			send_request(REQ_ADVANCE, s, d, 1'($urandom), $urandom);
		else
			send_request(REQ_NONE, s, d, 1'($urandom), $urandom);
	endtask

	task automatic configure(logic m, logic [7:0] gp, logic [3:0] il, logic [3:0] ol,
			logic [3:0] nn, logic [1:0] vv);
		write_register(REG_ARBITER_MODE, 32'(m));
		write_register(REG_GRANT_PERIOD, 32'(gp));
		write_register(REG_IN_LIMIT, 32'(il));
		write_register(REG_OUT_LIMIT, 32'(ol));
		write_register(REG_NODES, 32'(nn));
		write_register(REG_VCS, 32'(vv));
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	initial begin
		sb = new();
		cycle_count = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: extremes of fields, each request type, bad pushes and pops,
		// and the unknown request type, at reset settings.
		send_request(REQ_PUSH, 3'd0, 3'd7, 1'b0, 32'hFFFF_FFFF);
		send_request(REQ_PUSH, 3'd7, 3'd0, 1'b0, 32'h0000_0000);
		send_request(REQ_PUSH, 3'd1, 3'd7, 1'b1, 32'hA5A5_5A5A);
		send_request(REQ_POP, 3'd7, 3'd7, 1'b0, 0);
		send_request(REQ_ADVANCE, 3'd0, 3'd0, 1'b0, 0);
		send_request(REQ_POP, 3'd7, 3'd7, 1'b0, 0);
		send_request(REQ_POP, 3'd0, 3'd0, 1'b0, 0);
		send_request(REQ_POP, 3'd0, 3'd0, 1'b1, 0);
		send_request(REQ_NONE, 3'd5, 3'd2, 1'b1, 32'h1234_5678);
		drain();
		// Tiny queues so the input side overflows, then a stranded destination
		// once the node count shrinks below it.
		configure(1'b1, 8'd0, 4'd1, 4'd1, 4'd8, 2'd2);
		send_request(REQ_PUSH, 3'd2, 3'd6, 1'b1, 32'h0000_0001);
		send_request(REQ_PUSH, 3'd2, 3'd6, 1'b1, 32'h0000_0002);
		send_request(REQ_PUSH, 3'd3, 3'd6, 1'b1, 32'h0000_0003);
		send_request(REQ_ADVANCE, 0, 0, 0, 0);
		send_request(REQ_ADVANCE, 0, 0, 0, 0);
		send_request(REQ_POP, 3'd0, 3'd6, 1'b1, 0);
		send_request(REQ_PUSH, 3'd4, 3'd7, 1'b0, 32'h0000_0004);
		drain();
		configure(1'b0, 8'd255, 4'd15, 4'd0, 4'd0, 2'd0);
		send_request(REQ_PUSH, 3'd1, 3'd0, 1'b0, 32'h0000_0005);
		send_request(REQ_ADVANCE, 0, 0, 0, 0);
		send_request(REQ_ADVANCE, 0, 0, 0, 0);
		send_request(REQ_POP, 3'd0, 3'd7, 1'b0, 0);
		drain();

		// Random phases over several settings and idling patterns.
		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			case (ph)
				0: configure(1'b0, 8'd1, 4'd8, 4'd8, 4'd8, 2'd2);
				1: configure(1'b1, 8'd1, 4'd8, 4'd8, 4'd8, 2'd2);
				2: configure(1'b1, 8'd3, 4'd2, 4'd1, 4'd2, 2'd1);
				3: configure(1'b0, 8'd255, 4'd1, 4'd8, 4'd3, 2'd2);
				4: configure(1'b1, 8'd0, 4'd4, 4'd2, 4'd5, 2'd3);
				5: configure(1'b0, 8'd7, 4'd12, 4'd12, 4'd15, 2'd1);
				6: configure(1'b1, 8'd2, 4'd8, 4'd3, 4'd8, 2'd2);
				7: configure(1'b1, 8'd255, 4'd3, 4'd8, 4'd4, 2'd2);
				8: configure(1'b0, 8'd1, 4'd8, 4'd1, 4'd6, 2'd2);
				default: configure(1'b1, 8'd1, 4'd0, 4'd8, 4'd8, 2'd2);
			endcase
			for (int k = 0; k < 100; k++) begin
				random_item(sb.n_eff(), sb.v_eff());
				// Once per phase, hold the sender until every result is back.
				if (k == 50) begin
					req_valid <= 0;
					while (sb.pending.size() != 0) @(posedge clk);
				end
			end
			drain();
		end

		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

>>> files.f
sv/vcxb_pkg.sv
sv/vcxb_ram.sv
sv/vc_crossbar_switch_arbiter_top.sv
bench/vc_crossbar_switch_arbiter_top_tb.sv
